/* hw/rtl/bezier_fit_max_error_scan_macros.svh */
// Assertion macros used by the port checker of the Bezier error scan.
`ifndef BEZIER_FIT_MAX_ERROR_SCAN_MACROS_SVH
`define BEZIER_FIT_MAX_ERROR_SCAN_MACROS_SVH

// Check that cons holds in the same cycle as ante; needs clock and reset in scope.
`define BFME_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bfme port check failed");

// Check that cons holds in the cycle after ante; needs clock and reset in scope.
`define BFME_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bfme port check failed");

`endif

/* hw/rtl/bfme_pkg.sv */
// Types, codes and fixed widths shared by the Bezier error scan modules.
package bfme_pkg;

   // Fixed field widths
   localparam int COORD_FIELD_BITS = 24;
   localparam int Q16_BITS         = 17;
   localparam int INDEX_FIELD_BITS = 16;
   localparam int ERR_BITS         = 50;

   // Shared multiplier and datapath widths
   localparam int MUL_A_BITS = 32;
   localparam int MUL_B_BITS = 26;
   localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;
   localparam int BASIS_BITS = 18;
   localparam int FRAC_BITS  = 16;
   localparam int DIFF_BITS  = PROD_BITS - FRAC_BITS;
   localparam int MAG_BITS   = 25;

   localparam int                  ROUND_HALF = 32768;
   localparam logic [Q16_BITS-1:0] ONE_Q16    = 17'd65536;
   localparam logic [ERR_BITS-1:0] ERR_MAX    = '1;

   // Control register map
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_COUNT      = 8;
   localparam int CSR_START_X    = 0;
   localparam int CSR_START_Y    = 1;
   localparam int CSR_LEAD_X     = 2;
   localparam int CSR_LEAD_Y     = 3;
   localparam int CSR_TRAIL_X    = 4;
   localparam int CSR_TRAIL_Y    = 5;
   localparam int CSR_FINISH_X   = 6;
   localparam int CSR_FINISH_Y   = 7;

   typedef struct packed {
      logic signed [COORD_FIELD_BITS-1:0] sample_x;
      logic signed [COORD_FIELD_BITS-1:0] sample_y;
      logic [Q16_BITS-1:0]                param_t;
      logic [INDEX_FIELD_BITS-1:0]        sample_index;
      logic                               last_sample;
   } req_type;

   typedef struct packed {
      logic [ERR_BITS-1:0]         max_sq_error;
      logic [INDEX_FIELD_BITS-1:0] max_index;
      logic                        found;
   } rsp_type;

   typedef enum logic {
      SEQ_IDLE,
      SEQ_CALC
   } seq_state_type;

   // Sequencer steps; most are named after the product issued to the multiplier
   typedef enum logic [4:0] {
      STEP_UU,
      STEP_TT,
      STEP_B0,
      STEP_B1,
      STEP_B2,
      STEP_B3,
      STEP_X0,
      STEP_X1,
      STEP_X2,
      STEP_X3,
      STEP_Y0,
      STEP_Y1,
      STEP_Y2,
      STEP_Y3,
      STEP_DXX,
      STEP_DY,
      STEP_DYY,
      STEP_SUM,
      STEP_UPD
   } step_type;

   typedef struct packed {
      logic     busy;
      step_type step;
   } seq_ctrl_type;

endpackage

/* hw/rtl/bezier_fit_max_error_scan.sv */
// A result is registered at the update step of a last-marked transaction.
// The input stalls while a transaction is worked on; the 19 steps share one 32x26 multiplier.
// A full result register that is stalled keeps the last step of a last-marked transaction parked until it drains.
// Reset (synchronous, active high) clears the control points, the running maximum,
// the sequencer and the result valid.
module bezier_fit_max_error_scan
   import bfme_pkg::*;
#(
   parameter int INDEX_BITS = 16,
   parameter int COORD_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  req_type                       req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output rsp_type                       rsp_data,
   input  logic                          csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [COORD_FIELD_BITS-1:0]   csr_wdata
);

   localparam int CoordShift = MUL_A_BITS - COORD_BITS;

   // Keep the low COORD_BITS of a field and sign-extend from there
   function automatic logic signed [MUL_A_BITS-1:0] coord_ext(
      input logic [COORD_FIELD_BITS-1:0] raw
   );
      logic [MUL_A_BITS-1:0] wide;
      wide = MUL_A_BITS'(raw) << CoordShift;
      return $signed(wide) >>> CoordShift;
   endfunction

   seq_ctrl_type ctrl;
   logic         start;
   logic         hold;
   logic         finish;

   logic signed [MUL_A_BITS-1:0] op_a;
   logic signed [MUL_B_BITS-1:0] op_b;
   logic signed [PROD_BITS-1:0]  mul_prod;

   // Control points
   logic [COORD_FIELD_BITS-1:0] cfg_ff [CSR_COUNT];
   logic [COORD_FIELD_BITS-1:0] cfg_in [CSR_COUNT];

   // Transaction operands
   logic [Q16_BITS-1:0]          t_ff, t_in, u_ff, u_in;
   logic signed [MUL_A_BITS-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic [INDEX_BITS-1:0]        idx_ff, idx_in;
   logic                         last_ff, last_in;

   // Working values
   logic [Q16_BITS-1:0]         u2_ff, u2_in, t2_ff, t2_in;
   logic [BASIS_BITS-1:0]       b0_ff, b0_in, b1_ff, b1_in, b2_ff, b2_in, b3_ff, b3_in;
   logic signed [PROD_BITS-1:0] acc_ff, acc_in;
   logic [MAG_BITS-1:0]         dxa_ff, dxa_in, dya_ff, dya_in;
   logic                        satx_ff, satx_in, saty_ff, saty_in;
   logic [ERR_BITS-1:0]         errx_ff, errx_in, err_ff, err_in;

   // Running maximum and result register
   logic [ERR_BITS-1:0]   best_err_ff, best_err_in;
   logic [INDEX_BITS-1:0] best_idx_ff, best_idx_in;
   logic                  best_vld_ff, best_vld_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   // Derived datapath terms
   logic [Q16_BITS-1:0]         t_sat;
   logic [35:0]                 rnd_sum;
   logic [Q16_BITS-1:0]         rnd_q;
   logic [BASIS_BITS-1:0]       rnd_x3;
   logic signed [PROD_BITS-1:0] bias_x, bias_y, acc_sum;
   logic [DIFF_BITS-1:0]        diff, diff_mag;
   logic                        diff_sat;
   logic [ERR_BITS:0]           err_sum;
   logic                        err_gt;
   logic [ERR_BITS-1:0]         new_err;
   logic [INDEX_BITS-1:0]       new_idx;
   logic                        new_vld;

   assign start     = req_valid && !req_stall;
   assign hold      = last_ff && rsp_valid_ff && rsp_stall;
   assign finish    = ctrl.busy && (ctrl.step == STEP_UPD) && !hold;
   assign req_stall = ctrl.busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   bfme_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (start),
      .hold  (hold),
      .ctrl  (ctrl)
   );

   bfme_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (mul_prod)
   );

   // Select multiplier operands for the current step
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (ctrl.step)
         STEP_UU: begin
            op_a = MUL_A_BITS'(u_ff);
            op_b = MUL_B_BITS'(u_ff);
         end
         STEP_TT: begin
            op_a = MUL_A_BITS'(t_ff);
            op_b = MUL_B_BITS'(t_ff);
         end
         STEP_B0: begin
            op_a = MUL_A_BITS'(u2_ff);
            op_b = MUL_B_BITS'(u_ff);
         end
         STEP_B1: begin
            op_a = MUL_A_BITS'(u2_ff);
            op_b = MUL_B_BITS'(t_ff);
         end
         STEP_B2: begin
            op_a = MUL_A_BITS'(t2_ff);
            op_b = MUL_B_BITS'(u_ff);
         end
         STEP_B3: begin
            op_a = MUL_A_BITS'(t2_ff);
            op_b = MUL_B_BITS'(t_ff);
         end
         STEP_X0: begin
            op_a = coord_ext(cfg_ff[CSR_START_X]);
            op_b = MUL_B_BITS'(b0_ff);
         end
         STEP_X1: begin
            op_a = coord_ext(cfg_ff[CSR_LEAD_X]);
            op_b = MUL_B_BITS'(b1_ff);
         end
         STEP_X2: begin
            op_a = coord_ext(cfg_ff[CSR_TRAIL_X]);
            op_b = MUL_B_BITS'(b2_ff);
         end
         STEP_X3: begin
            op_a = coord_ext(cfg_ff[CSR_FINISH_X]);
            op_b = MUL_B_BITS'(b3_ff);
         end
         STEP_Y0: begin
            op_a = coord_ext(cfg_ff[CSR_START_Y]);
            op_b = MUL_B_BITS'(b0_ff);
         end
         STEP_Y1: begin
            op_a = coord_ext(cfg_ff[CSR_LEAD_Y]);
            op_b = MUL_B_BITS'(b1_ff);
         end
         STEP_Y2: begin
            op_a = coord_ext(cfg_ff[CSR_TRAIL_Y]);
            op_b = MUL_B_BITS'(b2_ff);
         end
         STEP_Y3: begin
            op_a = coord_ext(cfg_ff[CSR_FINISH_Y]);
            op_b = MUL_B_BITS'(b3_ff);
         end
         STEP_DXX: begin
            op_a = MUL_A_BITS'(dxa_ff);
            op_b = MUL_B_BITS'(dxa_ff);
         end
         STEP_DYY: begin
            op_a = MUL_A_BITS'(dya_ff);
            op_b = MUL_B_BITS'(dya_ff);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // Shared terms: rounded basis product, curve minus sample, squared sum, compare
   always_comb begin
      t_sat    = (req_data.param_t > ONE_Q16) ? ONE_Q16 : req_data.param_t;
      rnd_sum  = 36'(mul_prod) + 36'(ROUND_HALF);
      rnd_q    = rnd_sum[FRAC_BITS+Q16_BITS-1:FRAC_BITS];
      rnd_x3   = BASIS_BITS'(rnd_q) + BASIS_BITS'({rnd_q, 1'b0});
      bias_x   = PROD_BITS'(ROUND_HALF) - (PROD_BITS'(sx_ff) <<< FRAC_BITS);
      bias_y   = PROD_BITS'(ROUND_HALF) - (PROD_BITS'(sy_ff) <<< FRAC_BITS);
      acc_sum  = acc_ff + mul_prod;
      diff     = acc_ff[PROD_BITS-1:FRAC_BITS];
      diff_mag = diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : diff;
      diff_sat = |diff_mag[DIFF_BITS-1:MAG_BITS];
      err_sum  = {1'b0, errx_ff} + {1'b0, mul_prod[ERR_BITS-1:0]};
      err_gt   = (err_ff > best_err_ff);
      new_err  = err_gt ? err_ff : best_err_ff;
      new_idx  = err_gt ? idx_ff : best_idx_ff;
      new_vld  = err_gt || best_vld_ff;
   end

   // Next values of every register
   always_comb begin
      cfg_in       = cfg_ff;
      t_in         = t_ff;
      u_in         = u_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      u2_in        = u2_ff;
      t2_in        = t2_ff;
      b0_in        = b0_ff;
      b1_in        = b1_ff;
      b2_in        = b2_ff;
      b3_in        = b3_ff;
      acc_in       = acc_ff;
      dxa_in       = dxa_ff;
      dya_in       = dya_ff;
      satx_in      = satx_ff;
      saty_in      = saty_ff;
      errx_in      = errx_ff;
      err_in       = err_ff;
      best_err_in  = best_err_ff;
      best_idx_in  = best_idx_ff;
      best_vld_in  = best_vld_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      // Write a control point; drop writes beyond the map
      if (csr_write_en && (csr_index < CSR_INDEX_BITS'(CSR_COUNT))) begin
         cfg_in[csr_index[$clog2(CSR_COUNT)-1:0]] = csr_wdata;
      end

      // Capture the accepted transaction
      if (start) begin
         t_in    = t_sat;
         u_in    = ONE_Q16 - t_sat;
         sx_in   = coord_ext(req_data.sample_x);
         sy_in   = coord_ext(req_data.sample_y);
         idx_in  = INDEX_BITS'(req_data.sample_index);
         last_in = req_data.last_sample;
      end

      // Take the product issued one step earlier
      if (ctrl.busy) begin
         case (ctrl.step)
            STEP_TT:  u2_in = rnd_q;
            STEP_B0:  t2_in = rnd_q;
            STEP_B1:  b0_in = BASIS_BITS'(rnd_q);
            STEP_B2:  b1_in = rnd_x3;
            STEP_B3:  b2_in = rnd_x3;
            STEP_X0:  b3_in = BASIS_BITS'(rnd_q);
            STEP_X1:  acc_in = bias_x + mul_prod;
            STEP_X2, STEP_X3, STEP_Y0, STEP_Y2, STEP_Y3, STEP_DXX: acc_in = acc_sum;
            STEP_Y1: begin
               acc_in  = bias_y + mul_prod;
               dxa_in  = diff_mag[MAG_BITS-1:0];
               satx_in = diff_sat;
            end
            STEP_DY: begin
               errx_in = mul_prod[ERR_BITS-1:0];
               dya_in  = diff_mag[MAG_BITS-1:0];
               saty_in = diff_sat;
            end
            STEP_SUM: begin
               err_in = (satx_ff || saty_ff || err_sum[ERR_BITS]) ? ERR_MAX
                                                                  : err_sum[ERR_BITS-1:0];
            end
            default: begin
            end
         endcase
      end

      // Update the running maximum; on the last point emit it and clear
      if (finish) begin
         if (last_ff) begin
            rsp_valid_in             = 1'b1;
            rsp_data_in.max_sq_error = new_err;
            rsp_data_in.max_index    = new_vld ? INDEX_FIELD_BITS'(new_idx) : '0;
            rsp_data_in.found        = new_vld;
            best_err_in              = '0;
            best_idx_in              = '0;
            best_vld_in              = 1'b0;
         end else begin
            best_err_in = new_err;
            best_idx_in = new_idx;
            best_vld_in = new_vld;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CSR_COUNT; i++) begin
            cfg_ff[i] <= '0;
         end
         best_err_ff  <= '0;
         best_idx_ff  <= '0;
         best_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         best_err_ff  <= best_err_in;
         best_idx_ff  <= best_idx_in;
         best_vld_ff  <= best_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload state
   always_ff @(posedge clock) begin
      t_ff        <= t_in;
      u_ff        <= u_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      idx_ff      <= idx_in;
      last_ff     <= last_in;
      u2_ff       <= u2_in;
      t2_ff       <= t2_in;
      b0_ff       <= b0_in;
      b1_ff       <= b1_in;
      b2_ff       <= b2_in;
      b3_ff       <= b3_in;
      acc_ff      <= acc_in;
      dxa_ff      <= dxa_in;
      dya_ff      <= dya_in;
      satx_ff     <= satx_in;
      saty_ff     <= saty_in;
      errx_ff     <= errx_in;
      err_ff      <= err_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

/* hw/rtl/bfme_mul.sv */
// Shared signed multiplier with a registered product.
module bfme_mul
   import bfme_pkg::*;
(
   input  logic                         clock,
   input  logic signed [MUL_A_BITS-1:0] op_a,
   input  logic signed [MUL_B_BITS-1:0] op_b,
   output logic signed [PROD_BITS-1:0]  prod
);

   logic signed [PROD_BITS-1:0] prod_ff;
   logic signed [PROD_BITS-1:0] prod_in;

   // Form the product
   always_comb begin
      prod_in = op_a * op_b;
   end

   // Register the product
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

/* hw/rtl/bfme_seq.sv */
// Step sequencer that walks one transaction through the shared multiplier.
module bfme_seq
   import bfme_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         hold,
   output seq_ctrl_type ctrl
);

   seq_state_type state_ff;
   seq_state_type state_in;
   step_type      step_ff;
   step_type      step_in;

   // Advance through the steps, park on the last one while hold marks a full, stalled result slot
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (start) begin
               state_in = SEQ_CALC;
               step_in  = STEP_UU;
            end
         end
         SEQ_CALC: begin
            if (step_ff == STEP_UPD) begin
               if (!hold) begin
                  state_in = SEQ_IDLE;
                  step_in  = STEP_UU;
               end
            end else begin
               step_in = step_type'(step_ff + 1'b1);
            end
         end
         default: begin
            state_in = SEQ_IDLE;
            step_in  = STEP_UU;
         end
      endcase
      ctrl.busy = (state_ff == SEQ_CALC);
      ctrl.step = step_ff;
   end

   // Hold state and step
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         step_ff  <= STEP_UU;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

/* hw/rtl/bfme_check.sv */
// Port checker for the Bezier error scan, bound to the top level.
`include "bezier_fit_max_error_scan_macros.svh"

module bfme_check
   import bfme_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // A stalled result stays offered
   `BFME_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)

   // An accepted transaction keeps the input stalled while it is worked on
   `BFME_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)

   // Nothing found reports zero error and zero index
   `BFME_ASSERT_NOW(a_empty_zero, rsp_valid && !rsp_data.found,
                    (rsp_data.max_sq_error == '0) && (rsp_data.max_index == '0))

   // A found maximum is strictly positive
   `BFME_ASSERT_NOW(a_found_nonzero, rsp_valid && rsp_data.found,
                    rsp_data.max_sq_error != '0)

endmodule

bind bezier_fit_max_error_scan bfme_check u_bfme_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

/* tb/sv/bezier_fit_max_error_scan_test.sv */
// Self-checking testbench for the cubic Bezier maximum squared error scan.
`timescale 1ns / 1ps

module bezier_fit_max_error_scan_test;
   import bfme_pkg::*;

   localparam int  CYCLE_LIMIT   = 400000;
   localparam int  SETTLE_CYCLES = 40;
   localparam int  DRAIN_CYCLES  = 60;
   localparam int  HOLD_CYCLES   = 600;
   localparam int  PRINT_CAP     = 40;
   localparam logic signed [COORD_FIELD_BITS-1:0] COORD_MAX = 24'sh7FFFFF;
   localparam logic signed [COORD_FIELD_BITS-1:0] COORD_MIN = 24'sh800000;

   // Receiver stall patterns
   typedef enum logic [1:0] {
      FLOW_FREE,
      FLOW_SPARSE,
      FLOW_HALF,
      FLOW_PULSED
   } flow_mode_type;

   // Kinds of random data points
   typedef enum logic [1:0] {
      PICK_NEAR,
      PICK_EXACT,
      PICK_TIE,
      PICK_WILD
   } pick_type;

   // Tracks the running maximum error per segment and the results it implies
   class max_error_tracker;
      logic signed [COORD_FIELD_BITS-1:0] ctrl_pt [CSR_COUNT];
      longint                             best_error;
      logic [INDEX_FIELD_BITS-1:0]        best_index;
      bit                                 best_valid;
      rsp_type                            pending_maxima [$];
      int                                 mismatches;

      function new();
         foreach (ctrl_pt[k]) ctrl_pt[k] = '0;
         best_error = 0;
         best_index = '0;
         best_valid = 1'b0;
         mismatches = 0;
      endfunction

      // Mirror a register write; indexes past the map are dropped
      function void set_point(input int idx, input logic [COORD_FIELD_BITS-1:0] value);
         if (idx < CSR_COUNT) ctrl_pt[idx] = value;
      endfunction

      function longint round_mul(input longint a, input longint b);
         return (a * b + ROUND_HALF) >> FRAC_BITS;
      endfunction

      // Evaluate the curve in Bernstein form, signed Q24.0 result in coordinate units
      function void curve_at(input logic [Q16_BITS-1:0] t_raw,
                             output longint cx, output longint cy);
         longint t, u, u2, t2, b0, b1, b2, b3, sx, sy;
         t = longint'(t_raw);
         if (t > longint'(ONE_Q16)) t = longint'(ONE_Q16);
         u  = longint'(ONE_Q16) - t;
         u2 = round_mul(u, u);
         t2 = round_mul(t, t);
         b0 = round_mul(u2, u);
         b1 = 3 * round_mul(u2, t);
         b2 = 3 * round_mul(u, t2);
         b3 = round_mul(t2, t);
         sx = ctrl_pt[CSR_START_X] * b0 + ctrl_pt[CSR_LEAD_X] * b1
            + ctrl_pt[CSR_TRAIL_X] * b2 + ctrl_pt[CSR_FINISH_X] * b3;
         sy = ctrl_pt[CSR_START_Y] * b0 + ctrl_pt[CSR_LEAD_Y] * b1
            + ctrl_pt[CSR_TRAIL_Y] * b2 + ctrl_pt[CSR_FINISH_Y] * b3;
         cx = (sx + ROUND_HALF) >>> FRAC_BITS;
         cy = (sy + ROUND_HALF) >>> FRAC_BITS;
      endfunction

      function longint sq_error(input req_type s);
         longint cx, cy, dx, dy, err;
         curve_at(s.param_t, cx, cy);
         dx  = cx - longint'(s.sample_x);
         dy  = cy - longint'(s.sample_y);
         err = dx * dx + dy * dy;
         if (err > longint'(ERR_MAX)) err = longint'(ERR_MAX);
         return err;
      endfunction

      // Fold an accepted transaction into the running maximum
      function void note_sample(input req_type s);
         longint  err;
         rsp_type want;
         err = sq_error(s);
         if (err > best_error) begin
            best_error = err;
            best_index = s.sample_index;
            best_valid = 1'b1;
         end
         if (s.last_sample) begin
            want.max_sq_error = ERR_BITS'(best_error);
            want.max_index    = best_valid ? best_index : '0;
            want.found        = best_valid;
            pending_maxima    = {pending_maxima, want};
            best_error = 0;
            best_index = '0;
            best_valid = 1'b0;
         end
      endfunction

      task report_mismatch(input string what, input longint got, input longint want);
         if (mismatches < PRINT_CAP)
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
         mismatches++;
      endtask

      // Compare one result transaction with the oldest expected maximum
      task check_result(input rsp_type got);
         rsp_type want;
         if (pending_maxima.size() == 0) begin
            report_mismatch("unexpected result, error", got.max_sq_error, 0);
         end else begin
            want = pending_maxima.pop_front();
            if (got.max_sq_error !== want.max_sq_error)
               report_mismatch("max_sq_error", got.max_sq_error, want.max_sq_error);
            if (got.max_index !== want.max_index)
               report_mismatch("max_index", got.max_index, want.max_index);
            if (got.found !== want.found)
               report_mismatch("found", got.found, want.found);
         end
      endtask
   endclass

   logic                          clock;
   logic                          reset        = 1'b1;
   logic                          req_valid    = 1'b0;
   logic                          req_stall;
   req_type                       req_data     = '0;
   logic                          rsp_valid;
   logic                          rsp_stall    = 1'b0;
   rsp_type                       rsp_data;
   logic                          csr_write_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0]     csr_index    = '0;
   logic [COORD_FIELD_BITS-1:0]   csr_wdata    = '0;

   max_error_tracker board = new();
   int               cycle_count = 0;
   int               burst_left  = 0;
   int               hold_left   = 0;
   int               mode_left   = 0;
   flow_mode_type    flow_mode   = FLOW_FREE;
   req_type          prev_item   = '0;

   bezier_fit_max_error_scan uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Count cycles and end a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Check result transactions and drive the receiver stall pattern
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (cycle_count == 3000 || cycle_count == 20000) begin
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            flow_mode <= flow_mode_type'($urandom_range(0, 3));
            mode_left <= $urandom_range(16, 200);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (flow_mode)
            FLOW_FREE:   rsp_stall <= 1'b0;
            FLOW_SPARSE: rsp_stall <= ($urandom_range(0, 7) == 0);
            FLOW_HALF:   rsp_stall <= 1'($urandom_range(0, 1));
            default:     rsp_stall <= (cycle_count % 7 < 3);
         endcase
      end
   end

   // Offer one transaction, hold it until accepted, then maybe open a gap
   task automatic send_sample(input req_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      board.note_sample(item);
      prev_item = item;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(0, 30);
      end
   endtask

   // Drop valid and wait until the block has gone quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (board.pending_maxima.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_point(input int idx, input logic [COORD_FIELD_BITS-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_INDEX_BITS'(idx);
      csr_wdata    <= value;
      @(posedge clock);
      board.set_point(idx, value);
   endtask

   // Load all four control points plus one write outside the map
   task automatic load_curve(input int phase);
      logic [COORD_FIELD_BITS-1:0] pts [CSR_COUNT];
      int                          span;
      span = $urandom_range(8, 23);
      foreach (pts[k]) begin
         case (phase % 5)
            0:       pts[k] = COORD_FIELD_BITS'($urandom);
            1:       pts[k] = COORD_MAX;
            2:       pts[k] = COORD_MIN;
            3:       pts[k] = (k % 3 == 0) ? COORD_MIN : COORD_MAX;
            default: pts[k] = 24'($signed($urandom_range(0, (1 << span) - 1))
                                  - (1 << (span - 1)));
         endcase
      end
      foreach (pts[k]) write_point(k, pts[k]);
      write_point(CSR_COUNT + (phase % CSR_COUNT), COORD_FIELD_BITS'($urandom));
      csr_write_en <= 1'b0;
   endtask

   function automatic req_type make_point(input logic [Q16_BITS-1:0] t,
                                          input longint nx, input longint ny,
                                          input int idx, input bit last);
      req_type item;
      longint  cx, cy;
      board.curve_at(t, cx, cy);
      item.sample_x     = 24'(cx + nx);
      item.sample_y     = 24'(cy + ny);
      item.param_t      = t;
      item.sample_index = INDEX_FIELD_BITS'(idx);
      item.last_sample  = last;
      return item;
   endfunction

   function automatic req_type raw_point(input logic [COORD_FIELD_BITS-1:0] x,
                                         input logic [COORD_FIELD_BITS-1:0] y,
                                         input logic [Q16_BITS-1:0] t,
                                         input int idx, input bit last);
      req_type item;
      item.sample_x     = x;
      item.sample_y     = y;
      item.param_t      = t;
      item.sample_index = INDEX_FIELD_BITS'(idx);
      item.last_sample  = last;
      return item;
   endfunction

   // Extremes, ties, t past one and empty segments
   task automatic run_directed();
      send_sample(raw_point(0, 0, 0, 5, 1'b1));
      settle();
      write_point(CSR_START_X,  COORD_MAX);
      write_point(CSR_START_Y,  COORD_MIN);
      write_point(CSR_LEAD_X,   COORD_MIN);
      write_point(CSR_LEAD_Y,   COORD_MAX);
      write_point(CSR_TRAIL_X,  COORD_MAX);
      write_point(CSR_TRAIL_Y,  COORD_MAX);
      write_point(CSR_FINISH_X, COORD_MIN);
      write_point(CSR_FINISH_Y, COORD_MIN);
      write_point(15, COORD_MAX);
      csr_write_en <= 1'b0;
      send_sample(raw_point(COORD_MIN, COORD_MAX, 0, 0, 1'b0));
      send_sample(raw_point(COORD_MIN, COORD_MAX, 0, 16'hFFFF, 1'b0));
      send_sample(raw_point(COORD_MAX, COORD_MAX, ONE_Q16, 1, 1'b0));
      send_sample(raw_point(COORD_MIN, COORD_MIN, 17'h1FFFF, 2, 1'b1));
      send_sample(raw_point(0, 0, 17'd32768, 16'hFFFF, 1'b1));
      send_sample(raw_point(COORD_MAX, COORD_MIN, 17'd1, 3, 1'b0));
      send_sample(raw_point(COORD_MIN, COORD_MIN, 17'd65535, 4, 1'b1));
      send_sample(raw_point(0, 0, 17'd65537, 6, 1'b0));
      send_sample(make_point(0, 0, 0, 7, 1'b1));
      send_sample(make_point(0, 0, 0, 8, 1'b1));
      send_sample(make_point(ONE_Q16, 0, 0, 9, 1'b0));
      send_sample(make_point(17'd20000, 0, 0, 10, 1'b1));
      send_sample(make_point(17'd40000, 1, 0, 11, 1'b0));
      send_sample(make_point(17'd41000, 0, -1, 12, 1'b1));
   endtask

   // Mostly well-formed segments of near-curve points, with wild and broken ones mixed in
   task automatic run_random(input int budget);
      int       sent, seg_len, base, shape, amp;
      pick_type pick;
      req_type  item;
      logic [Q16_BITS-1:0] t;
      bit       last;
      sent = 0;
      while (sent < budget) begin
         shape   = $urandom_range(0, 9);
         seg_len = (shape == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
         base    = $urandom_range(0, 65535);
         for (int k = 0; k < seg_len; k++) begin
            last = (shape == 9) ? 1'($urandom_range(0, 1)) : (k == seg_len - 1);
            case ($urandom_range(0, 9))
               0:       pick = PICK_EXACT;
               1:       pick = PICK_TIE;
               2:       pick = PICK_WILD;
               default: pick = PICK_NEAR;
            endcase
            t = ($urandom_range(0, 15) == 0) ? Q16_BITS'($urandom_range(65537, 131071))
                                             : Q16_BITS'($urandom_range(0, 65536));
            case ($urandom_range(0, 3))
               0:       amp = 4;
               1:       amp = 4096;
               2:       amp = 1 << 20;
               default: amp = 64;
            endcase
            case (pick)
               PICK_EXACT: item = make_point(t, 0, 0, base + k, last);
               PICK_TIE: begin
                  item = prev_item;
                  item.sample_index = INDEX_FIELD_BITS'(base + k);
                  item.last_sample  = last;
               end
               PICK_WILD: begin
                  item = raw_point(COORD_FIELD_BITS'($urandom), COORD_FIELD_BITS'($urandom),
                                   Q16_BITS'($urandom), int'($urandom),
                                   1'($urandom_range(0, 1)));
               end
               default: begin
                  item = make_point(t, longint'($urandom_range(0, 2 * amp)) - amp,
                                    longint'($urandom_range(0, 2 * amp)) - amp,
                                    base + k, last);
               end
            endcase
            send_sample(item);
            sent++;
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      for (int phase = 0; phase < 8; phase++) begin
         settle();
         load_curve(phase);
         run_random(175);
      end
      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.pending_maxima.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
